### sv/cmh_pkg.sv
package cmh_pkg;

  localparam int CAPACITY  = 8;
  localparam int IDX_W     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int USED_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 64;
  localparam int COUNT_W   = 16;
  localparam int ENTRIES_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_HIT,
    EMIT_NEW,
    EMIT_DROP,
    EMIT_EMPTY,
    EMIT_DUMP
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  idx_inc;
    logic  rd_idx;
    logic  rd_walk;
    logic  wr_hit;
    logic  wr_new;
    logic  wr_swap_p;
    logic  wr_swap_n;
    logic  walk_start;
    logic  walk_up;
    logic  walk_next;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic used_zero;
    logic used_gt1;
    logic is_full;
    logic key_match;
    logic idx_last;
    logic swap_need;
    logic p_root;
    logic k_last;
  } sts_t;

endpackage

### sv/cmh_ram.sv
module cmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re_a,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                        rdata_a,
  input  logic                                    re_b,
  input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                        rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_r <= mem_r[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### sv/cmh_dp.sv
module cmh_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cmh_pkg::cmd_t                   cmd,
  output cmh_pkg::sts_t                   sts,
  input  logic [cmh_pkg::KEY_W-1:0]       in_location_key,
  output logic                            out_valid,
  output logic [cmh_pkg::KEY_W-1:0]       out_entry_key,
  output logic [cmh_pkg::COUNT_W-1:0]     out_entry_count,
  output logic [cmh_pkg::ENTRIES_W-1:0]   out_entries_used,
  output logic                            out_was_new,
  output logic                            out_dropped,
  output logic                            out_valid_res,
  output logic                            out_last
);

  logic [cmh_pkg::KEY_W-1:0]     key_r;
  logic [cmh_pkg::IDX_W-1:0]     idx_r;
  logic [cmh_pkg::IDX_W-1:0]     k_r;
  logic [cmh_pkg::IDX_W-1:0]     n_r;
  logic [cmh_pkg::USED_W-1:0]    used_r;
  logic [cmh_pkg::COUNT_W-1:0]   cnt_r;

  logic                          out_valid_r;
  logic [cmh_pkg::KEY_W-1:0]     out_key_r;
  logic [cmh_pkg::COUNT_W-1:0]   out_count_r;
  logic [cmh_pkg::ENTRIES_W-1:0] out_used_r;
  logic                          out_new_r;
  logic                          out_drop_r;
  logic                          out_vres_r;
  logic                          out_last_r;

  cmh_pkg::entry_t               rd_a;
  cmh_pkg::entry_t               rd_b;
  cmh_pkg::entry_t               wdata;
  logic [cmh_pkg::IDX_W-1:0]     waddr;
  logic                          we;
  logic [cmh_pkg::IDX_W-1:0]     p_w;
  logic [cmh_pkg::IDX_W-1:0]     raddr_a;
  logic [cmh_pkg::COUNT_W-1:0]   inc_cnt;
  logic [cmh_pkg::USED_W-1:0]    used_inc;
  logic [cmh_pkg::USED_W-1:0]    used_after;
  logic [cmh_pkg::COUNT_W-1:0]   hit_cnt;

  cmh_ram #(
    .WIDTH($bits(cmh_pkg::entry_t)),
    .DEPTH(cmh_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (cmd.rd_idx | cmd.rd_walk),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .re_b    (cmd.rd_walk),
    .raddr_b (p_w),
    .rdata_b (rd_b)
  );

  assign p_w      = (n_r - cmh_pkg::IDX_W'(1)) >> 1;
  assign raddr_a  = cmd.rd_walk ? n_r : idx_r;
  assign inc_cnt  = (rd_a.count == cmh_pkg::COUNT_MAX) ? rd_a.count
                                                        : rd_a.count + cmh_pkg::COUNT_W'(1);
  assign used_inc = used_r + cmh_pkg::USED_W'(1);
  assign used_after = cmd.wr_new ? used_inc : used_r;
  assign hit_cnt  = cmd.wr_hit ? inc_cnt : cnt_r;

  // single write port shared by hit update, append and swap halves
  always_comb begin
    we    = cmd.wr_hit | cmd.wr_new | cmd.wr_swap_p | cmd.wr_swap_n;
    waddr = idx_r;
    wdata = rd_a;
    if (cmd.wr_hit) begin
      waddr       = idx_r;
      wdata.key   = key_r;
      wdata.count = inc_cnt;
    end else if (cmd.wr_new) begin
      waddr       = cmh_pkg::IDX_W'(used_r);
      wdata.key   = key_r;
      wdata.count = cmh_pkg::COUNT_W'(1);
    end else if (cmd.wr_swap_p) begin
      waddr = p_w;
      wdata = rd_a;
    end else if (cmd.wr_swap_n) begin
      waddr = n_r;
      wdata = rd_b;
    end
  end

  always_comb begin
    sts.used_zero = (used_r == '0);
    sts.used_gt1  = (used_r > cmh_pkg::USED_W'(1));
    sts.is_full   = (used_r >= cmh_pkg::USED_W'(cmh_pkg::CAPACITY));
    sts.key_match = (rd_a.key == key_r);
    sts.idx_last  = ((cmh_pkg::USED_W'(idx_r) + cmh_pkg::USED_W'(1)) >= used_r);
    sts.swap_need = (rd_b.count < rd_a.count);
    sts.p_root    = (p_w == '0);
    sts.k_last    = ((cmh_pkg::USED_W'(k_r) + cmh_pkg::USED_W'(1)) >= used_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_new) begin
        used_r <= used_inc;
      end
      out_valid_r <= (cmd.emit != cmh_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_location_key;
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + cmh_pkg::IDX_W'(1);
    end
    if (cmd.wr_hit) begin
      cnt_r <= inc_cnt;
    end
    if (cmd.walk_start) begin
      k_r <= cmh_pkg::IDX_W'(1);
      n_r <= cmh_pkg::IDX_W'(1);
    end else if (cmd.walk_up) begin
      n_r <= p_w;
    end else if (cmd.walk_next) begin
      k_r <= k_r + cmh_pkg::IDX_W'(1);
      n_r <= k_r + cmh_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    out_used_r <= cmh_pkg::ENTRIES_W'(used_after);
    out_new_r  <= 1'b0;
    out_drop_r <= 1'b0;
    out_vres_r <= 1'b1;
    out_last_r <= 1'b1;
    case (cmd.emit)
      cmh_pkg::EMIT_HIT: begin
        out_key_r   <= key_r;
        out_count_r <= hit_cnt;
      end
      cmh_pkg::EMIT_NEW: begin
        out_key_r   <= key_r;
        out_count_r <= cmh_pkg::COUNT_W'(1);
        out_new_r   <= 1'b1;
      end
      cmh_pkg::EMIT_DROP: begin
        out_key_r   <= key_r;
        out_count_r <= '0;
        out_drop_r  <= 1'b1;
      end
      cmh_pkg::EMIT_EMPTY: begin
        out_key_r   <= '0;
        out_count_r <= '0;
        out_vres_r  <= 1'b0;
      end
      cmh_pkg::EMIT_DUMP: begin
        out_key_r   <= rd_a.key;
        out_count_r <= rd_a.count;
        out_last_r  <= sts.idx_last;
      end
      default: begin
        out_key_r   <= out_key_r;
        out_count_r <= out_count_r;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_entry_key    = out_key_r;
  assign out_entry_count  = out_count_r;
  assign out_entries_used = out_used_r;
  assign out_was_new      = out_new_r;
  assign out_dropped      = out_drop_r;
  assign out_valid_res    = out_vres_r;
  assign out_last         = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= cmh_pkg::USED_W'(cmh_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |=> used_r == $past(used_inc))
    else $error("append did not advance entry count");

endmodule

### sv/cmh_ctrl.sv
module cmh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_operation,
  output logic          busy,
  output cmh_pkg::cmd_t cmd,
  input  cmh_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS,
    S_SORT_RD,
    S_SORT_CMP,
    S_SWAP_N,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   advance;

  always_comb begin
    state_nxt = state_r;
    advance   = 1'b0;
    cmd       = '0;
    cmd.emit  = cmh_pkg::EMIT_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_operation) begin
            if (sts.used_zero) begin
              cmd.emit = cmh_pkg::EMIT_EMPTY;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end else begin
            state_nxt = sts.used_zero ? S_MISS : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.key_match) begin
          cmd.wr_hit = 1'b1;
          if (sts.used_gt1) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_SORT_RD;
          end else begin
            cmd.emit  = cmh_pkg::EMIT_HIT;
            state_nxt = S_IDLE;
          end
        end else if (sts.idx_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_MISS: begin
        if (sts.is_full) begin
          cmd.emit = cmh_pkg::EMIT_DROP;
        end else begin
          cmd.wr_new = 1'b1;
          cmd.emit   = cmh_pkg::EMIT_NEW;
        end
        state_nxt = S_IDLE;
      end
      S_SORT_RD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (sts.swap_need) begin
          cmd.wr_swap_p = 1'b1;
          state_nxt     = S_SWAP_N;
        end else begin
          advance = 1'b1;
        end
      end
      S_SWAP_N: begin
        cmd.wr_swap_n = 1'b1;
        advance       = 1'b1;
      end
      S_DUMP_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        cmd.emit = cmh_pkg::EMIT_DUMP;
        if (sts.idx_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step one level up the walk, or start the next walk, or finish
    if (advance) begin
      if (!sts.p_root) begin
        cmd.walk_up = 1'b1;
        state_nxt   = S_SORT_RD;
      end else if (!sts.k_last) begin
        cmd.walk_next = 1'b1;
        state_nxt     = S_SORT_RD;
      end else begin
        cmd.emit  = cmh_pkg::EMIT_HIT;
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted word");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP_N |-> $past(state_r) == S_SORT_CMP && $past(sts.swap_need))
    else $error("swap second half without first half");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> !sts.is_full)
    else $error("append into a full store");

endmodule

### sv/counting_max_heap.sv
// channel   ports                          handshake
// input     in_operation, in_location_key  start high while busy low
// result    out_* fields                   out_valid strobe, one cycle each
//
// insert: each entry scanned is read, then compared; a miss then appends or drops the key;
//   a hit then re-sorts, each parent compare being one memory read and one or two writes
// dump: each entry is read from the store, then emitted; an empty dump emits a single word
// reset clears the entry count and the controller; the store itself is not cleared
// results cannot be stalled: each word is on the out_ ports for exactly one cycle
module counting_max_heap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [cmh_pkg::KEY_W-1:0]       in_location_key,
  output logic                            out_valid,
  output logic [cmh_pkg::KEY_W-1:0]       out_entry_key,
  output logic [cmh_pkg::COUNT_W-1:0]     out_entry_count,
  output logic [cmh_pkg::ENTRIES_W-1:0]   out_entries_used,
  output logic                            out_was_new,
  output logic                            out_dropped,
  output logic                            out_valid_res,
  output logic                            out_last
);

  cmh_pkg::cmd_t cmd;
  cmh_pkg::sts_t sts;

  cmh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .busy         (busy),
    .cmd          (cmd),
    .sts          (sts)
  );

  cmh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_location_key  (in_location_key),
    .out_valid        (out_valid),
    .out_entry_key    (out_entry_key),
    .out_entry_count  (out_entry_count),
    .out_entries_used (out_entries_used),
    .out_was_new      (out_was_new),
    .out_dropped      (out_dropped),
    .out_valid_res    (out_valid_res),
    .out_last         (out_last)
  );

endmodule

### tb/cmh_checker.sv
package cmh_tb_pkg;
  import cmh_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [COUNT_W-1:0]   count;
    logic [ENTRIES_W-1:0] used;
    logic                 was_new;
    logic                 dropped;
    logic                 valid_res;
    logic                 last;
  } heap_word_t;
endpackage

module cmh_checker
  import cmh_pkg::*;
  import cmh_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_operation,
  input  logic [KEY_W-1:0]     in_location_key,
  input  logic                 out_valid,
  input  logic [KEY_W-1:0]     out_entry_key,
  input  logic [COUNT_W-1:0]   out_entry_count,
  input  logic [ENTRIES_W-1:0] out_entries_used,
  input  logic                 out_was_new,
  input  logic                 out_dropped,
  input  logic                 out_valid_res,
  input  logic                 out_last,
  output int                   errors,
  output int                   pending
);

  logic [KEY_W-1:0]   heap_keys   [CAPACITY];
  logic [COUNT_W-1:0] heap_counts [CAPACITY];
  int                 heap_used;
  heap_word_t         expected_words [$];

  function automatic string word_str(input heap_word_t w);
    return $sformatf("key=%h count=%0d used=%0d new=%b drop=%b valid=%b last=%b",
                     w.key, w.count, w.used, w.was_new, w.dropped, w.valid_res, w.last);
  endfunction

  task automatic reheap();
    int k;
    int n;
    int p;
    logic [KEY_W-1:0]   tk;
    logic [COUNT_W-1:0] tc;
    for (k = 1; k < heap_used; k++) begin
      n = k;
      do begin
        p = (n - 1) / 2;
        if (heap_counts[p] < heap_counts[n]) begin
          tk = heap_keys[p];
          tc = heap_counts[p];
          heap_keys[p] = heap_keys[n];
          heap_counts[p] = heap_counts[n];
          heap_keys[n] = tk;
          heap_counts[n] = tc;
        end
        n = p;
      end while (n != 0);
    end
  endtask

  task automatic predict_words(input logic op, input logic [KEY_W-1:0] key);
    int i;
    int hit_at;
    heap_word_t w;
    w = '0;
    if (op == OP_DUMP) begin
      if (heap_used == 0) begin
        w.last = 1'b1;
        expected_words.push_back(w);
      end else begin
        for (i = 0; i < heap_used; i++) begin
          w.key = heap_keys[i];
          w.count = heap_counts[i];
          w.used = ENTRIES_W'(heap_used);
          w.valid_res = 1'b1;
          w.last = (i == heap_used - 1);
          expected_words.push_back(w);
        end
      end
    end else begin
      hit_at = -1;
      for (i = 0; i < heap_used; i++)
        if (hit_at < 0 && heap_keys[i] == key) hit_at = i;
      w.key = key;
      w.valid_res = 1'b1;
      w.last = 1'b1;
      if (hit_at >= 0) begin
        if (heap_counts[hit_at] != COUNT_MAX) heap_counts[hit_at] = heap_counts[hit_at] + 1'b1;
        w.count = heap_counts[hit_at];
        reheap();
      end else if (heap_used >= CAPACITY) begin
        w.dropped = 1'b1;
      end else begin
        heap_keys[heap_used] = key;
        heap_counts[heap_used] = COUNT_W'(1);
        heap_used++;
        w.was_new = 1'b1;
        w.count = COUNT_W'(1);
      end
      w.used = ENTRIES_W'(heap_used);
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    heap_word_t got;
    heap_word_t want;
    if (!rst_n) begin
      heap_used = 0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        got = '{out_entry_key, out_entry_count, out_entries_used, out_was_new,
                out_dropped, out_valid_res, out_last};
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: %s", $time, word_str(got));
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (got.key !== want.key || got.count !== want.count || got.used !== want.used ||
              got.was_new !== want.was_new || got.dropped !== want.dropped ||
              got.valid_res !== want.valid_res || got.last !== want.last) begin
            $display("%0t mismatch: expected %s", $time, word_str(want));
            $display("%0t           actual   %s", $time, word_str(got));
            errors++;
          end
        end
      end
      if (start && !busy) predict_words(in_operation, in_location_key);
    end
    pending = expected_words.size();
  end

endmodule

### tb/tb_top.sv
module tb_top;
  import cmh_pkg::*;
  import cmh_tb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_operation;
  logic [KEY_W-1:0]     in_location_key;
  logic                 out_valid;
  logic [KEY_W-1:0]     out_entry_key;
  logic [COUNT_W-1:0]   out_entry_count;
  logic [ENTRIES_W-1:0] out_entries_used;
  logic                 out_was_new;
  logic                 out_dropped;
  logic                 out_valid_res;
  logic                 out_last;
  int                   errors;
  int                   pending;

  logic [KEY_W-1:0] stored_keys [$];
  bit               gaps_on;

  counting_max_heap u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_location_key  (in_location_key),
    .out_valid        (out_valid),
    .out_entry_key    (out_entry_key),
    .out_entry_count  (out_entry_count),
    .out_entries_used (out_entries_used),
    .out_was_new      (out_was_new),
    .out_dropped      (out_dropped),
    .out_valid_res    (out_valid_res),
    .out_last         (out_last)
  );

  cmh_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_location_key  (in_location_key),
    .out_valid        (out_valid),
    .out_entry_key    (out_entry_key),
    .out_entry_count  (out_entry_count),
    .out_entries_used (out_entries_used),
    .out_was_new      (out_was_new),
    .out_dropped      (out_dropped),
    .out_valid_res    (out_valid_res),
    .out_last         (out_last),
    .errors           (errors),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[counting_max_heap] ERROR");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    while (gaps_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      in_operation <= 1'($urandom_range(1));
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_location_key <= key;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic count_key(input logic [KEY_W-1:0] key);
    bit known;
    known = 1'b0;
    foreach (stored_keys[i]) if (stored_keys[i] == key) known = 1'b1;
    if (!known && stored_keys.size() < CAPACITY) stored_keys.push_back(key);
    send_word(OP_INSERT, key);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (64) @(negedge clk);
  endtask

  initial begin
    int r;
    logic [KEY_W-1:0] fresh;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_INSERT;
    in_location_key = '0;
    gaps_on = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty dump, then one key inserted back to back three times (a new entry, then two hits)
    send_word(OP_DUMP, {$urandom, $urandom});
    repeat (3) count_key({KEY_W{1'b1}});
    send_word(OP_DUMP, '0);

    gaps_on = 1'b1;
    count_key('0);
    count_key('0);
    send_word(OP_DUMP, {KEY_W{1'b1}});
    for (int i = 0; i < 6; i++) begin
      fresh = {$urandom, $urandom};
      count_key(fresh);
      if (i % 2 == 1) count_key(fresh);
      if (i == 4) count_key(fresh);
    end
    count_key({$urandom, $urandom});
    count_key('0);
    count_key(stored_keys[CAPACITY-1]);
    send_word(OP_DUMP, {$urandom, $urandom});
    drain();

    for (int n = 0; n < 310; n++) begin
      gaps_on = !(n >= 120 && n < 190);
      r = $urandom_range(99);
      if (r < 12)
        send_word(OP_DUMP, {$urandom, $urandom});
      else if (r < 27)
        count_key({$urandom, $urandom});
      else
        count_key(stored_keys[$urandom_range(stored_keys.size() - 1)]);
      if (n == 200) drain();
    end
    drain();

    if (errors == 0 && pending == 0)
      $display("[counting_max_heap] OK");
    else
      $display("[counting_max_heap] ERROR");
    $finish;
  end

endmodule
